// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the cache core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lkvc_pkg.sv =====
// Package with the shared types and constants of the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] NEG_ONE   = {VAL_W{1'b1}};

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MATCH  = 2'd1,
    ST_UPDATE = 2'd2
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic match_en;
    logic update;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lkvc_cell.sv =====
// One recency-ordered cell of the cache chain: entry storage and key compare.
`default_nettype none
module lkvc_cell #(
  parameter int IDX_W = 4,
  parameter int POS   = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lkvc_pkg::cell_ctrl_t      ctrl,
  input  logic [IDX_W-1:0]          upd_pos,
  input  logic [lkvc_pkg::KEY_W-1:0] probe_key,
  input  lkvc_pkg::entry_t          chain_in,
  output lkvc_pkg::entry_t          chain_out,
  output logic                      match_o
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [lkvc_pkg::KEY_W-1:0] key_r;
  logic [lkvc_pkg::KEY_W-1:0] key_nxt;
  logic [lkvc_pkg::VAL_W-1:0] value_r;
  logic [lkvc_pkg::VAL_W-1:0] value_nxt;
  logic                       match_r;
  logic                       match_nxt;
  logic                       take;

  // Take the neighbor's entry when this cell sits at or above the moved slot.
  assign take = ctrl.update && (IDX_W'(POS) <= upd_pos);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (take) begin
      valid_nxt = chain_in.valid;
      key_nxt   = chain_in.key;
      value_nxt = chain_in.value;
    end
  end

  assign match_nxt = ctrl.match_en ? (valid_r && (key_r == probe_key)) : match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign chain_out.valid = valid_r;
  assign chain_out.key   = key_r;
  assign chain_out.value = value_r;
  assign match_o         = match_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lkvc_hit_sel.sv =====
// Encode the one-hot match vector of the cells into a position and a value.
`default_nettype none
module lkvc_hit_sel #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic [ENTRIES-1:0]                      match,
  input  logic [ENTRIES-1:0][lkvc_pkg::VAL_W-1:0] values,
  output logic                                    hit,
  output logic [IDX_W-1:0]                        hit_idx,
  output logic [lkvc_pkg::VAL_W-1:0]              hit_value
);

  // Keys are unique among valid cells, so an OR tree encodes the match.
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_idx   = hit_idx | (match[i] ? IDX_W'(i) : '0);
      hit_value = hit_value | (match[i] ? values[i] : '0);
    end
  end

  assign hit = |match;

endmodule
`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_core.sv =====
// Top level of the fully associative LRU key-value cache core.
`default_nettype none
`include "assert_macros.svh"
// Fully associative key-value cache with least-recently-used replacement,
// built as a chain of ENTRIES cells kept in recency order: cell 0 holds the
// most recent entry, cell occupancy-1 the least recent. A transaction is a get
// or a put, taken at a rising edge with start high and busy low. Each
// transaction has a match cycle, in which every cell compares
// its key with the probe and registers the result (busy is high here), and an
// update cycle, in which the hit position is encoded, the cells above the
// touched slot shift one place down the chain and cell 0 loads the touched or
// new entry. A new transaction is taken during the update cycle, so the core
// can start the next transaction while the last one updates. The result (hit, read_value)
// appears on the out_ ports for exactly one cycle after the update cycle,
// marked by out_valid; there is no back-pressure, so capture it in that
// cycle. A get miss returns -1, as does every put. The capacity register
// limits the entries in use; 0 acts as 1 and values above ENTRIES saturate.
// Write it only while the core is idle. The store is empty after reset, with
// no clearing pass.
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic signed [lkvc_pkg::KEY_W-1:0]  in_key,
  input  logic signed [lkvc_pkg::VAL_W-1:0]  in_value,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic signed [lkvc_pkg::VAL_W-1:0]  out_read_value,
  input  logic                               cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

  // Control state.
  lkvc_pkg::state_t state_r;
  lkvc_pkg::state_t state_nxt;
  logic [lkvc_pkg::CAP_W-1:0] capacity_r;
  logic [lkvc_pkg::CAP_W-1:0] capacity_nxt;
  logic [OCC_W-1:0]           occ_r;
  logic [OCC_W-1:0]           occ_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;

  // Transaction and result payload.
  logic                       cmd_r;
  logic                       cmd_nxt;
  logic [lkvc_pkg::KEY_W-1:0] key_r;
  logic [lkvc_pkg::KEY_W-1:0] key_nxt;
  logic [lkvc_pkg::VAL_W-1:0] value_r;
  logic [lkvc_pkg::VAL_W-1:0] value_nxt;
  logic                       out_hit_r;
  logic                       out_hit_nxt;
  logic [lkvc_pkg::VAL_W-1:0] out_read_value_r;
  logic [lkvc_pkg::VAL_W-1:0] out_read_value_nxt;

  // Datapath.
  logic                                    accept;
  logic                                    upd_phase;
  lkvc_pkg::cell_ctrl_t                    cell_ctrl;
  lkvc_pkg::entry_t                        head;
  lkvc_pkg::entry_t                        cell_q [ENTRIES];
  logic [ENTRIES-1:0]                      match_vec;
  logic [ENTRIES-1:0]                      valid_vec;
  logic [ENTRIES-1:0][lkvc_pkg::VAL_W-1:0] value_vec;
  logic                                    hit;
  logic [IDX_W-1:0]                        hit_idx;
  logic [lkvc_pkg::VAL_W-1:0]              hit_value;
  logic [CMP_W-1:0]                        cap_ext;
  logic [CMP_W-1:0]                        eff_cap;
  logic [CMP_W-1:0]                        occ_ext;
  logic                                    evict;
  logic                                    is_put;
  logic [IDX_W-1:0]                        upd_pos;

  assign accept = start && !busy;
  assign is_put = (cmd_r == lkvc_pkg::CMD_PUT);

  // Next state: match, then update; a new transaction may enter during update.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (start) state_nxt = lkvc_pkg::ST_MATCH;
      end
      lkvc_pkg::ST_MATCH: begin
        state_nxt = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        state_nxt = start ? lkvc_pkg::ST_MATCH : lkvc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    busy               = 1'b0;
    cell_ctrl.match_en = 1'b0;
    upd_phase          = 1'b0;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      lkvc_pkg::ST_MATCH: begin
        busy               = 1'b1;
        cell_ctrl.match_en = 1'b1;
      end
      lkvc_pkg::ST_UPDATE: begin
        upd_phase = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Only a get miss leaves the chain untouched.
  assign cell_ctrl.update = upd_phase && (hit || is_put);

  // Clamp capacity into 1..ENTRIES and decide whether a put miss evicts.
  always_comb begin
    cap_ext = CMP_W'(capacity_r);
    occ_ext = CMP_W'(occ_r);
    eff_cap = cap_ext;
    if (cap_ext == '0) eff_cap = CMP_W'(1);
    if (cap_ext > CMP_W'(ENTRIES)) eff_cap = CMP_W'(ENTRIES);
    evict = (occ_ext >= eff_cap) || (occ_ext >= CMP_W'(ENTRIES));
  end

  // Slot that leaves its place: the hit, the least recent on eviction, or the
  // first free cell on a plain insert.
  always_comb begin
    if (hit) begin
      upd_pos = hit_idx;
    end else if (evict) begin
      upd_pos = IDX_W'(occ_r - OCC_W'(1));
    end else begin
      upd_pos = IDX_W'(occ_r);
    end
  end

  // Entry that enters cell 0 as the most recent.
  assign head.valid = 1'b1;
  assign head.key   = key_r;
  assign head.value = is_put ? value_r : hit_value;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_pkg::entry_t chain_in;
    if (g == 0) begin : g_head
      assign chain_in = head;
    end else begin : g_link
      assign chain_in = cell_q[g-1];
    end

    lkvc_cell #(
      .IDX_W (IDX_W),
      .POS   (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .upd_pos   (upd_pos),
      .probe_key (key_r),
      .chain_in  (chain_in),
      .chain_out (cell_q[g]),
      .match_o   (match_vec[g])
    );

    assign valid_vec[g] = cell_q[g].valid;
    assign value_vec[g] = cell_q[g].value;
  end

  lkvc_hit_sel #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_hit_sel (
    .match     (match_vec),
    .values    (value_vec),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .hit_value (hit_value)
  );

  // Grow occupancy only on a put miss that finds a free cell.
  always_comb begin
    occ_nxt = occ_r;
    if (cell_ctrl.update && !hit && !evict) occ_nxt = occ_r + OCC_W'(1);
  end

  assign capacity_nxt = cfg_we ? cfg_wdata : capacity_r;

  // Capture the transaction; hold it through match and update.
  assign cmd_nxt   = accept ? in_command : cmd_r;
  assign key_nxt   = accept ? in_key : key_r;
  assign value_nxt = accept ? in_value : value_r;

  // Drive the result for one cycle after the update.
  assign out_valid_nxt      = upd_phase;
  assign out_hit_nxt        = upd_phase ? hit : out_hit_r;
  assign out_read_value_nxt = upd_phase ? ((!is_put && hit) ? hit_value : lkvc_pkg::NEG_ONE)
                                        : out_read_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkvc_pkg::ST_IDLE;
      capacity_r  <= lkvc_pkg::CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r            <= cmd_nxt;
    key_r            <= key_nxt;
    value_r          <= value_nxt;
    out_hit_r        <= out_hit_nxt;
    out_read_value_r <= out_read_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

  // Valid cells form a contiguous run that the occupancy counts.
  `ASSERT_CLK(a_occ_count, $countones(valid_vec) == int'(occ_r), "valid cells differ from occupancy")
  `ASSERT_CLK(a_occ_max, int'(occ_r) <= ENTRIES, "occupancy above entry count")
  // Keys are unique among valid cells.
  `ASSERT_CLK(a_match_onehot, $onehot0(match_vec), "more than one cell matched the key")
  // A strobe follows every update cycle and nothing else.
  `ASSERT_IMPL(a_strobe_src, out_valid_r, $past(state_r) == lkvc_pkg::ST_UPDATE, "strobe without update")

endmodule
`default_nettype wire
